// ===== src/assert_macros.svh =====
// assertion macros used by the scheduler module
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_AT(label, clk, rstn, prop)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== src/mprqs_pkg.sv =====
// package for the ready queue scheduler: constants, entry type, command codes
// no dependencies
`default_nettype none
package mprqs_pkg;
  localparam int unsigned PoolDepth = 16;
  localparam int unsigned IdxW = $clog2(PoolDepth);
  localparam int unsigned CntW = $clog2(PoolDepth + 1);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_REMOVE = 3'd1, CMD_SELECT = 3'd2,
    CMD_TICK = 3'd3, CMD_QRESET = 3'd4, CMD_UPDATE = 3'd5,
    CMD_RSV6 = 3'd6, CMD_RSV7 = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    POL_RR = 2'd0, POL_SJF = 2'd1, POL_SRTF = 2'd2, POL_PRIO = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [0:0] {REG_POLICY = 1'b0, REG_QUANTUM = 1'b1} reg_e;

  typedef enum logic [2:0] {
    S_IDLE, S_REMOVE, S_SCAN, S_ROTATE, S_RESULT
  } state_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
  } entry_t;

  // per-cycle control from the sequencer to every cell
  typedef struct packed {
    logic   shift;    // every cell takes its right neighbor (ring)
    logic   drop;     // shift only cells at or after the drop point
    logic   load;     // write new entry at tail
    logic   update;   // remaining update on matching id
    logic [IdxW-1:0] tail;
    logic [IdxW-1:0] last;
    entry_t din;
  } cell_ctl_t;
endpackage
`default_nettype wire

// ===== src/mprqs_cell.sv =====
// one pool cell: holds an entry, shifts toward the front, loads new data or updates its remaining field
// depends on mprqs_pkg
`default_nettype none
module mprqs_cell (
  input  logic                clk_i,
  input  logic [mprqs_pkg::IdxW-1:0] pos_i,
  input  mprqs_pkg::cell_ctl_t ctl_i,
  input  logic                hold_i,
  input  mprqs_pkg::entry_t   next_i,
  input  mprqs_pkg::entry_t   front_i,
  output mprqs_pkg::entry_t   entry_o
);
  import mprqs_pkg::*;
  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift && !hold_i) begin
      entry_d = (pos_i == ctl_i.last) ? front_i : next_i;
    end else if (ctl_i.load && pos_i == ctl_i.tail) begin
      entry_d = ctl_i.din;
    end else if (ctl_i.update && entry_q.id == ctl_i.din.id) begin
      entry_d.remaining = ctl_i.din.remaining;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
endmodule
`default_nettype wire

// ===== src/multi_policy_ready_queue_scheduler.sv =====
// Ready queue scheduler: a chain of entry cells plus a command sequencer.
// A request passes from capture through S_RESULT into the output register,
// except remove (S_REMOVE first shifts each matching entry out of the pool
// in turn, then does the pick check) and select (S_SCAN compares one cell
// per cycle at the front of the chain while the chain rotates one full
// turn; the round robin rotate happens in the last scan cycle, and a select
// on an empty pool goes straight to S_RESULT with status empty). The
// result is held in an output register; a new request is taken once the
// result is taken.
// tdata in: command[2:0] proc_id[10:3] burst[26:11] remaining[42:27]
// prio[50:43]; tdata out: status[1:0] picked_valid[2] picked_id[10:3]
// pool_count[15:11] pool_empty[16]. Depends on mprqs_pkg, mprqs_cell.
`default_nettype none
`include "assert_macros.svh"
module multi_policy_ready_queue_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // command, proc_id, burst, remaining, priority
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // status, picked_valid, picked_id, pool_count, pool_empty
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mprqs_pkg::*;

  state_e state_q, state_d;
  logic [1:0]  policy_q;
  logic [15:0] quantum_q, qcnt_q, qcnt_d;
  logic [CntW-1:0] count_q, count_d;
  logic cur_v_q, cur_v_d;
  logic [7:0] cur_id_q, cur_id_d;
  logic [2:0] cmd_q;
  entry_t in_q;
  logic [CntW-1:0] step_q, step_d;
  entry_t bestv_q, bestv_d;
  logic found_q, found_d;
  logic [1:0] status_q, status_d;
  logic out_v_q;
  logic [23:0] out_q;
  cell_ctl_t ctl;
  entry_t cells [PoolDepth];
  logic [PoolDepth-1:0] hold;
  logic [IdxW-1:0] drop_pos;
  logic rm_hit;
  logic better;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  // first matching id for remove, scanned over the cells
  always_comb begin
    rm_hit = 1'b0;
    drop_pos = '0;
    for (int i = PoolDepth - 1; i >= 0; i--) begin
      if (CntW'(i) < count_q && cells[i].id == in_q.id) begin
        rm_hit = 1'b1;
        drop_pos = IdxW'(i);
      end
    end
  end

  for (genvar g = 0; g < PoolDepth; g++) begin : g_cell
    assign hold[g] = ctl.drop && (IdxW'(g) < drop_pos);
    mprqs_cell u_cell (
      .clk_i   (clk_i),
      .pos_i   (IdxW'(g)),
      .ctl_i   (ctl),
      .hold_i  (hold[g]),
      .next_i  (cells[(g + 1) % PoolDepth]),
      .front_i (ctl.drop ? cells[PoolDepth-1] : cells[0]),
      .entry_o (cells[g])
    );
  end

  // compare the front cell against the best so far
  always_comb begin
    case (policy_e'(policy_q))
      POL_PRIO: better = cells[0].prio > bestv_q.prio;
      POL_SRTF: better = cells[0].remaining < bestv_q.remaining;
      default:  better = cells[0].burst < bestv_q.burst;
    endcase
  end

  always_comb begin
    state_d = state_q;
    qcnt_d = qcnt_q;
    count_d = count_q;
    cur_v_d = cur_v_q;
    cur_id_d = cur_id_q;
    step_d = step_q;
    bestv_d = bestv_q;
    found_d = found_q;
    status_d = status_q;
    ctl = '0;
    ctl.din = in_q;
    ctl.tail = count_q[IdxW-1:0];
    ctl.last = count_q[IdxW-1:0] - 1'b1;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          state_d = S_RESULT;
          status_d = ST_OK;
          step_d = '0;
          found_d = 1'b0;
          case (cmd_e'(s_axis_tdata[2:0]))
            CMD_REMOVE: state_d = S_REMOVE;
            CMD_SELECT: state_d = S_SCAN;
            default: ;
          endcase
        end
      end
      S_REMOVE: begin
        if (rm_hit) begin
          ctl.shift = 1'b1;
          ctl.drop = 1'b1;
          ctl.last = IdxW'(PoolDepth - 1);
          count_d = count_q - 1'b1;
        end else begin
          if (cur_v_q && cur_id_q == in_q.id) begin
            cur_v_d = 1'b0;
            cur_id_d = '0;
            qcnt_d = '0;
          end
          state_d = S_RESULT;
        end
      end
      S_SCAN: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
          cur_v_d = 1'b0;
          cur_id_d = '0;
          state_d = S_RESULT;
        end else if (step_q < count_q) begin
          // chain rotates one step per cycle, cell 0 is entry step_q
          ctl.shift = 1'b1;
          step_d = step_q + 1'b1;
          if (!found_q && cur_v_q && cells[0].id == cur_id_q) begin
            found_d = 1'b1;
          end
          if (step_q == '0 || better) begin
            bestv_d = cells[0];
          end
        end else begin
          state_d = S_RESULT;
          cur_v_d = 1'b1;
          case (policy_e'(policy_q))
            POL_RR: begin
              if (found_q && qcnt_q < quantum_q) begin
                cur_id_d = cur_id_q;
              end else begin
                qcnt_d = '0;
                if (cur_v_q && cells[0].id == cur_id_q) begin
                  ctl.shift = 1'b1;
                  cur_id_d = cells[1].id;
                  if (count_q == CntW'(1)) cur_id_d = cells[0].id;
                end else begin
                  cur_id_d = cells[0].id;
                end
              end
            end
            POL_SJF: cur_id_d = found_q ? cur_id_q : bestv_q.id;
            default: cur_id_d = bestv_q.id;
          endcase
        end
      end
      S_RESULT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // add, tick, qreset and update act in the cycle after capture
    if (state_q == S_RESULT) begin
      case (cmd_e'(cmd_q))
        CMD_ADD: begin
          if (count_q >= CntW'(PoolDepth)) status_d = ST_FULL;
          else begin
            ctl.load = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        CMD_TICK: if (qcnt_q != 16'hFFFF) qcnt_d = qcnt_q + 1'b1;
        CMD_QRESET: qcnt_d = '0;
        CMD_UPDATE: ctl.update = 1'b1;
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] cnt_fin;
  logic [1:0] st_fin;
  assign cnt_fin = count_d;
  assign st_fin = status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      policy_q <= POL_RR;
      quantum_q <= 16'd4;
      qcnt_q <= '0;
      count_q <= '0;
      cur_v_q <= 1'b0;
      cur_id_q <= '0;
      out_v_q <= 1'b0;
      step_q <= '0;
      found_q <= 1'b0;
      status_q <= ST_OK;
      cmd_q <= CMD_RSV6;
    end else begin
      state_q <= state_d;
      qcnt_q <= qcnt_d;
      count_q <= count_d;
      cur_v_q <= cur_v_d;
      cur_id_q <= cur_id_d;
      step_q <= step_d;
      found_q <= found_d;
      status_q <= status_d;
      if (cfg_valid_i) begin
        case (reg_e'(cfg_index_i))
          REG_POLICY:  policy_q <= cfg_data_i[1:0];
          REG_QUANTUM: quantum_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) cmd_q <= s_axis_tdata[2:0];
      if (state_q == S_RESULT) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    bestv_q <= bestv_d;
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.id <= s_axis_tdata[10:3];
      in_q.burst <= s_axis_tdata[26:11];
      in_q.remaining <= s_axis_tdata[42:27];
      in_q.prio <= s_axis_tdata[50:43];
    end
    if (state_q == S_RESULT) begin
      out_q <= {7'd0, cnt_fin == '0, cnt_fin, cur_v_d ? cur_id_d : 8'd0, cur_v_d, st_fin};
    end
  end

  `ASSERT_AT(a_count_range, clk_i, rst_ni, count_q <= CntW'(PoolDepth))
  `ASSERT_AT(a_no_take_busy, clk_i, rst_ni, s_axis_tready |-> state_q == S_IDLE)
  `ASSERT_NEXT(a_result_follows, clk_i, rst_ni, state_q == S_RESULT, out_v_q)
endmodule
`default_nettype wire
